>>> design/chained_hash_accumulate_table_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash accumulate table checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_ACCUMULATE_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_ACCUMULATE_TABLE_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define CHAT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chat_checker: assertion failed");

// Checks that a condition never holds outside of reset.
`define CHAT_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("chat_checker: forbidden condition seen");

`endif

>>> design/chat_pkg.sv
// ----------------------------------------------------------------------------
// chat_pkg
// Shared constants, codes, result type and bucket hash for the chained hash
// accumulate table.
// ----------------------------------------------------------------------------
package chat_pkg;

  // Table geometry. Both sizes are powers of two.
  localparam int unsigned BUCKETS  = 1024;
  localparam int unsigned CAPACITY = 1024;

  localparam int unsigned BKT_W    = $clog2(BUCKETS);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 3;

  // Multiplicative hash constant.
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  // Capacity as a count; also the empty marker of a bucket head.
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_NEW        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd5;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index;
    logic [KEY_W-1:0]    key;
    logic [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]    used;
  } res_t;

  // The bucket is the low bits of key times the hash constant. Those bits
  // depend only on the low bits of both factors, so a narrow product suffices.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [2*BKT_W-1:0] prod;
    prod = (2*BKT_W)'(key[BKT_W-1:0]) * (2*BKT_W)'(HASH_MULT[BKT_W-1:0]);
    return prod[BKT_W-1:0];
  endfunction

endpackage

>>> design/chat_out_buf.sv
// ----------------------------------------------------------------------------
// chat_out_buf
// One-entry output register that decouples the table engine from the
// receiver of result items.
// ----------------------------------------------------------------------------
module chat_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  chat_pkg::res_t push_res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output chat_pkg::res_t out_res_o
);
  import chat_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Space exists when empty or when the held item leaves this cycle.
  assign push_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_valid_i && push_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Held payload.
  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      res_q <= push_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

>>> design/chained_hash_accumulate_table_core.sv
// ----------------------------------------------------------------------------
// chained_hash_accumulate_table_core
// Hash aggregation table: adds signed amounts under 64-bit keys, with chained
// buckets held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on in_valid_i/in_ready_o with func_i, key_i, amount_i
// and slot_i; each item gives exactly one result item on out_valid_o and
// out_ready_i. Items are worked on one at a time.
// An add occupies the engine from acceptance until the next item can be
// taken: it is accepted, its bucket head is read through the read port of
// the head memory, and then one chain entry at a time is read through the
// single read port of the entry memory. Its result is registered when the
// key is found or the chain ends, once the output register has space. A read
// item reads one entry. A clear item sweeps the bucket head memory one head
// per cycle, holding on the last head while the output register is full.
// After reset the same sweep empties the bucket heads; in_ready_o stays low
// until it is done.
// Results go through a one-entry output register, so the next item is taken
// while a result waits. If the receiver stalls, the finished item holds in
// the engine with its memory writes deferred until the register has space.
// ----------------------------------------------------------------------------
module chained_hash_accumulate_table_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [chat_pkg::FUNC_W-1:0]           func_i,
  input  logic [chat_pkg::KEY_W-1:0]            key_i,
  input  logic signed [chat_pkg::SUM_W-1:0]     amount_i,
  input  logic [chat_pkg::IDX_W-1:0]            slot_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [chat_pkg::STATUS_W-1:0]         status_o,
  output logic [chat_pkg::IDX_W-1:0]            entry_index_o,
  output logic [chat_pkg::KEY_W-1:0]            entry_key_o,
  output logic signed [chat_pkg::SUM_W-1:0]     entry_sum_o,
  output logic [chat_pkg::CNT_W-1:0]            entries_used_o
);
  import chat_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HEAD  = 6'b000100,
    S_WALK  = 6'b001000,
    S_READ  = 6'b010000,
    S_CLEAR = 6'b100000
  } state_e;

  // One table entry: chain link, key and running sum.
  typedef struct packed {
    logic [CNT_W-1:0] link;
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
  } entry_t;

  state_e state_q, state_d;

  logic [KEY_W-1:0] key_q;
  logic [SUM_W-1:0] amount_q;
  logic [BKT_W-1:0] bucket_q;
  logic [IDX_W-1:0] slot_q;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [BKT_W-1:0] sweep_q, sweep_d;

  // Bucket head memory.
  logic [CNT_W-1:0] head_mem [BUCKETS];
  logic             head_re, head_we;
  logic [BKT_W-1:0] head_raddr, head_waddr;
  logic [CNT_W-1:0] head_wdata, head_rdata_q;

  // Entry memory.
  entry_t           entry_mem [CAPACITY];
  logic             entry_re, entry_we;
  logic [IDX_W-1:0] entry_raddr, entry_waddr;
  entry_t           entry_wdata, entry_rdata_q;

  logic             in_acc;
  logic             do_merge, do_miss;
  logic [CNT_W-1:0] link_src;
  logic [SUM_W-1:0] merged_sum;
  logic             res_valid, res_ready;
  res_t             res, out_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign merged_sum = entry_rdata_q.sum + amount_q;
  // A miss found at the head uses the head just read; a miss at the chain
  // end uses the head saved on the way in.
  assign link_src   = (state_q == S_HEAD) ? head_rdata_q : head_q;

  // Sequencer. Memory writes land at the end of an item, before the next
  // item can issue a read, so no forwarding is needed.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    head_d      = head_q;
    fill_d      = fill_q;
    sweep_d     = sweep_q;
    head_re     = 1'b0;
    head_raddr  = bucket_of(key_i);
    head_we     = 1'b0;
    head_waddr  = sweep_q;
    head_wdata  = CAP_CNT;
    entry_re    = 1'b0;
    entry_raddr = slot_i;
    entry_we    = 1'b0;
    entry_waddr = cur_q;
    entry_wdata = entry_rdata_q;
    do_merge    = 1'b0;
    do_miss     = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    unique case (state_q)
      S_INIT: begin
        head_we = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == BKT_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_ADD: begin
              head_re = 1'b1;
              state_d = S_HEAD;
            end
            FUNC_CLEAR: begin
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            default: begin
              // Read, and the unused code that acts as read.
              entry_re = 1'b1;
              state_d  = S_READ;
            end
          endcase
        end
      end
      S_HEAD: begin
        head_d = head_rdata_q;
        if (head_rdata_q < fill_q) begin
          entry_re    = 1'b1;
          entry_raddr = head_rdata_q[IDX_W-1:0];
          cur_d       = head_rdata_q[IDX_W-1:0];
          state_d     = S_WALK;
        end else begin
          do_miss = 1'b1;
        end
      end
      S_WALK: begin
        // Links always point to older slots, so the walk visits each occupied
        // slot at most once and ends.
        if (entry_rdata_q.key == key_q) begin
          do_merge = 1'b1;
        end else if (entry_rdata_q.link < fill_q) begin
          entry_re    = 1'b1;
          entry_raddr = entry_rdata_q.link[IDX_W-1:0];
          cur_d       = entry_rdata_q.link[IDX_W-1:0];
        end else begin
          do_miss = 1'b1;
        end
      end
      S_READ: begin
        if (res_ready) begin
          res_valid = 1'b1;
          res.index = slot_q;
          if (CNT_W'(slot_q) < fill_q) begin
            res.status = ST_READ_OK;
            res.key    = entry_rdata_q.key;
            res.sum    = entry_rdata_q.sum;
          end else begin
            res.status = ST_READ_EMPTY;
          end
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        head_we = 1'b1;
        if (sweep_q == BKT_LAST) begin
          // Hold on the last head until the result can be registered.
          if (res_ready) begin
            res_valid  = 1'b1;
            res.status = ST_CLEARED;
            fill_d     = '0;
            sweep_d    = '0;
            state_d    = S_IDLE;
          end
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    // Key found: write back the updated sum.
    if (do_merge && res_ready) begin
      entry_we        = 1'b1;
      entry_waddr     = cur_q;
      entry_wdata.sum = merged_sum;
      res_valid       = 1'b1;
      res.status      = ST_MERGED;
      res.index       = cur_q;
      res.key         = key_q;
      res.sum         = merged_sum;
      state_d         = S_IDLE;
    end

    // Key not found: append at the next free slot, or drop when full.
    if (do_miss && res_ready) begin
      res_valid = 1'b1;
      state_d   = S_IDLE;
      if (fill_q == CAP_CNT) begin
        res.status = ST_FULL;
      end else begin
        entry_we         = 1'b1;
        entry_waddr      = fill_q[IDX_W-1:0];
        entry_wdata.link = link_src;
        entry_wdata.key  = key_q;
        entry_wdata.sum  = amount_q;
        head_we          = 1'b1;
        head_waddr       = bucket_q;
        head_wdata       = fill_q;
        fill_d           = fill_q + 1'b1;
        res.status       = ST_NEW;
        res.index        = fill_q[IDX_W-1:0];
        res.key          = key_q;
        res.sum          = amount_q;
      end
    end

    res.used = fill_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      fill_q  <= '0;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      sweep_q <= sweep_d;
    end
  end

  // Item payload and walk position.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q    <= key_i;
      amount_q <= amount_i;
      bucket_q <= bucket_of(key_i);
      slot_q   <= slot_i;
    end
    cur_q  <= cur_d;
    head_q <= head_d;
  end

  // Bucket head memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rdata_q <= head_mem[head_raddr];
    end
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    if (entry_re) begin
      entry_rdata_q <= entry_mem[entry_raddr];
    end
  end

  // Output register.
  chat_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_ready_o (res_ready),
    .push_res_i   (res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_res_o    (out_res)
  );

  assign status_o       = out_res.status;
  assign entry_index_o  = out_res.index;
  assign entry_key_o    = out_res.key;
  assign entry_sum_o    = $signed(out_res.sum);
  assign entries_used_o = out_res.used;

endmodule

>>> design/chat_checker.sv
// ----------------------------------------------------------------------------
// chat_checker
// Port-level checks for the hash accumulate table, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_accumulate_table_core_defines.svh"

module chat_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [chat_pkg::FUNC_W-1:0]       func_i,
  input logic [chat_pkg::KEY_W-1:0]        key_i,
  input logic signed [chat_pkg::SUM_W-1:0] amount_i,
  input logic [chat_pkg::IDX_W-1:0]        slot_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [chat_pkg::STATUS_W-1:0]     status_o,
  input logic [chat_pkg::IDX_W-1:0]        entry_index_o,
  input logic [chat_pkg::KEY_W-1:0]        entry_key_o,
  input logic signed [chat_pkg::SUM_W-1:0] entry_sum_o,
  input logic [chat_pkg::CNT_W-1:0]        entries_used_o
);
  import chat_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Items accepted whose result has not yet been taken.
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result holds its fields.
  `CHAT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(entry_index_o) && $stable(entry_key_o) && $stable(entry_sum_o) && $stable(entries_used_o))

  // No result appears without an item behind it.
  `CHAT_ASSERT_NEVER(a_out_without_item, out_valid_o && (pend_q == 2'd0))

  // The engine works on one item; at most one result waits when it takes more.
  `CHAT_ASSERT(a_one_in_flight, in_acc |-> pend_q <= 2'd1)

  // A new entry always lands at the last occupied slot.
  `CHAT_ASSERT(a_new_slot_is_last, out_valid_o && (status_o == ST_NEW) |-> CNT_W'(entry_index_o) == entries_used_o - CNT_W'(1))

  // A clear leaves the table empty.
  `CHAT_ASSERT(a_clear_empties, out_valid_o && (status_o == ST_CLEARED) |-> (entries_used_o == '0) && (entry_index_o == '0))

endmodule

bind chained_hash_accumulate_table_core chat_checker u_chat_checker (.*);
